// ===== hdl/zrvd_pkg.sv =====
package zrvd_pkg;

   // Fixed field widths.
   localparam int CLUSTER_COUNT_W = 12;
   localparam int BYTE_W          = 8;
   localparam int WORD_BYTES      = 8;
   localparam int WORD_W          = BYTE_W * WORD_BYTES;
   localparam int PACK_W          = WORD_W - BYTE_W;
   localparam int FILL_W          = 3;
   localparam int COUNT_W         = 4;

   // Row length as computed from the cluster count, before narrowing.
   localparam int ROW_CALC_W = 10;

   // Default for the MAX_ROW_BYTES parameter.
   localparam int DEF_MAX_ROW_BYTES = 256;

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] REG_CLUSTER_COUNT = 1'b0;
   localparam logic [CLUSTER_COUNT_W-1:0] CLUSTER_COUNT_RESET = 12'd2048;

   // Request codes and fill value.
   localparam logic REQ_STREAM = 1'b0;
   localparam logic REQ_NOVIS  = 1'b1;
   localparam logic [BYTE_W-1:0] NOVIS_BYTE = 8'hFF;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_run;
      logic emit;
      logic run_done;
      logic out_free;
   } sts_type;

   // Row length in bytes: cluster count divided by eight, rounded up,
   // then held within one and the largest row.
   function automatic logic [ROW_CALC_W-1:0] row_len_calc(
      input logic [CLUSTER_COUNT_W-1:0] cc,
      input int max_bytes
   );
      logic [CLUSTER_COUNT_W:0] sum;
      logic [ROW_CALC_W-1:0]    len;
      int                       m;
      sum = {1'b0, cc} + (CLUSTER_COUNT_W+1)'(7);
      len = sum[CLUSTER_COUNT_W:3];
      m   = max_bytes;
      if (len == '0) begin
         len = ROW_CALC_W'(1);
      end else if (int'(len) > m) begin
         len = m[ROW_CALC_W-1:0];
      end
      return len;
   endfunction

endpackage

// ===== hdl/zero_run_visibility_row_decoder.sv =====
// Channel   Direction  Handshake                 Payload
// req       in         req_valid / req_ready     req_type, req_in_byte
// rsp       out        rsp_valid / rsp_ready     rsp_out_word, rsp_valid_bytes, rsp_row_end,
//                                                rsp_overrun, rsp_last_of_item
// csr       in         psel / penable / pready   paddr, pwdata, pwrite, prdata
//
// An item is taken first, then the packer places it in chunks of up to eight bytes, each
// no larger than the free room of the packed word: a literal is a single chunk, while a zero
// run of c bytes or a no-vis row of ROW bytes is split over as many chunks as it needs.
// The packer places one chunk and emits at most one word per cycle while it is not held.
// A word waits in the output register; the packer holds while that register is full.
// Reset is synchronous; afterwards cluster_count is 2048 and no row is in progress.
module zero_run_visibility_row_decoder #(
   parameter int MAX_ROW_BYTES = zrvd_pkg::DEF_MAX_ROW_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [zrvd_pkg::BYTE_W-1:0]       req_in_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [zrvd_pkg::WORD_W-1:0]       rsp_out_word,
   output logic [zrvd_pkg::COUNT_W-1:0]      rsp_valid_bytes,
   output logic                              rsp_row_end,
   output logic                              rsp_overrun,
   output logic                              rsp_last_of_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [zrvd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [zrvd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [zrvd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import zrvd_pkg::*;

   localparam int ROW_W = $clog2(MAX_ROW_BYTES + 1);

   cmd_type          cmd;
   sts_type          sts;
   logic             cfg_wr;
   logic [ROW_W-1:0] row_len;

   assign pready = 1'b1;

   // Configuration registers.
   zrvd_csr #(
      .MAX_ROW_BYTES(MAX_ROW_BYTES),
      .ROW_W        (ROW_W)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .cfg_wr (cfg_wr),
      .row_len(row_len)
   );

   // Sequencing of item intake and packing steps.
   zrvd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .cmd      (cmd),
      .sts      (sts)
   );

   // Run expansion, byte packing and the output register.
   zrvd_dp #(
      .ROW_W(ROW_W)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_in_byte     (req_in_byte),
      .cfg_wr          (cfg_wr),
      .row_len         (row_len),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_word    (rsp_out_word),
      .rsp_valid_bytes (rsp_valid_bytes),
      .rsp_row_end     (rsp_row_end),
      .rsp_overrun     (rsp_overrun),
      .rsp_last_of_item(rsp_last_of_item)
   );

endmodule

// ===== hdl/zrvd_csr.sv =====
module zrvd_csr #(
   parameter int MAX_ROW_BYTES = 256,
   parameter int ROW_W         = 9
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [zrvd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [zrvd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [zrvd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               cfg_wr,
   output logic [ROW_W-1:0]                   row_len
);
   import zrvd_pkg::*;

   localparam logic [ROW_CALC_W-1:0] ROW_RESET =
      row_len_calc(CLUSTER_COUNT_RESET, MAX_ROW_BYTES);

   logic [CLUSTER_COUNT_W-1:0] cluster_count_ff;
   logic [ROW_W-1:0]           row_len_ff;
   logic [CSR_IDX_W-1:0]       reg_idx;
   logic [ROW_CALC_W-1:0]      row_calc;

   // Register index is the word address.
   assign reg_idx  = paddr[CSR_ADDR_W-1:2];
   assign cfg_wr   = psel && penable && pwrite && (reg_idx == REG_CLUSTER_COUNT);
   assign row_calc = row_len_calc(pwdata[CLUSTER_COUNT_W-1:0], MAX_ROW_BYTES);

   // Cluster count and the row length derived from it.
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_count_ff <= CLUSTER_COUNT_RESET;
         row_len_ff       <= ROW_RESET[ROW_W-1:0];
      end else if (cfg_wr) begin
         cluster_count_ff <= pwdata[CLUSTER_COUNT_W-1:0];
         row_len_ff       <= row_calc[ROW_W-1:0];
      end
   end

   // Read back.
   always_comb begin
      case (reg_idx)
         REG_CLUSTER_COUNT:
            prdata = {{(CSR_DATA_W-CLUSTER_COUNT_W){1'b0}}, cluster_count_ff};
         default:
            prdata = '0;
      endcase
   end

   assign row_len = row_len_ff;

endmodule

// ===== hdl/zrvd_ctrl.sv =====
module zrvd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output zrvd_pkg::cmd_type cmd,
   input  zrvd_pkg::sts_type sts
);
   import zrvd_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // An item is taken only between runs.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // One chunk a cycle, held while a word waits for a full output register.
   assign cmd.load = accept;
   assign cmd.step = (state_ff == ST_RUN) && (!sts.emit || sts.out_free);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && sts.load_run) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cmd.step && sts.run_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/zrvd_dp.sv =====
module zrvd_dp #(
   parameter int ROW_W = 9
) (
   input  logic                              clock,
   input  logic                              reset,
   input  zrvd_pkg::cmd_type                 cmd,
   output zrvd_pkg::sts_type                 sts,
   input  logic                              req_type,
   input  logic [zrvd_pkg::BYTE_W-1:0]       req_in_byte,
   input  logic                              cfg_wr,
   input  logic [ROW_W-1:0]                  row_len,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [zrvd_pkg::WORD_W-1:0]       rsp_out_word,
   output logic [zrvd_pkg::COUNT_W-1:0]      rsp_valid_bytes,
   output logic                              rsp_row_end,
   output logic                              rsp_overrun,
   output logic                              rsp_last_of_item
);
   import zrvd_pkg::*;

   localparam int CMP_W = (ROW_W > BYTE_W) ? ROW_W : BYTE_W;

   // Row and run state.
   logic                awaiting_ff;
   logic [ROW_W-1:0]    bytes_done_ff;
   logic [PACK_W-1:0]   pack_ff;
   logic [FILL_W-1:0]   fill_ff;
   logic [ROW_W-1:0]    run_left_ff;
   logic [BYTE_W-1:0]   run_val_ff;
   logic                ovr_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   word_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                row_end_ff;
   logic                overrun_ff;
   logic                last_ff;

   // Item decode.
   logic                is_novis;
   logic                byte_nz;
   logic [ROW_W-1:0]    remaining;
   logic                clip;

   // Chunk step.
   logic [COUNT_W-1:0]  room;
   logic [COUNT_W-1:0]  k;
   logic [COUNT_W-1:0]  fill_sum;
   logic [ROW_W-1:0]    bd_sum;
   logic [ROW_W-1:0]    bd_next;
   logic [ROW_W-1:0]    rl_next;
   logic                at_end;
   logic                emit;
   logic                last_word;
   logic [WORD_W-1:0]   pack_ext;
   logic [WORD_W-1:0]   word_nx;

   assign is_novis  = (req_type == REQ_NOVIS);
   assign byte_nz   = (req_in_byte != '0);
   assign remaining = row_len - bytes_done_ff;
   assign clip      = CMP_W'(req_in_byte) > CMP_W'(remaining);

   // Bytes placed this cycle: up to the free room of the packed word.
   assign room     = COUNT_W'(WORD_BYTES) - {1'b0, fill_ff};
   assign k        = (run_left_ff < ROW_W'(room)) ? run_left_ff[COUNT_W-1:0] : room;
   assign fill_sum = {1'b0, fill_ff} + k;
   assign bd_sum   = bytes_done_ff + ROW_W'(k);
   assign at_end   = (bd_sum == row_len);
   assign emit     = fill_sum[COUNT_W-1] || at_end;
   assign bd_next  = at_end ? '0 : bd_sum;
   assign rl_next  = run_left_ff - ROW_W'(k);

   // This word is the item's last when no later chunk will emit one.
   assign last_word = (rl_next == '0) ||
                      ((rl_next < ROW_W'(WORD_BYTES)) && ((bd_next + rl_next) != row_len));

   // Merge the run value into the bytes above the current fill.
   assign pack_ext = {{BYTE_W{1'b0}}, pack_ff};
   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         if (COUNT_W'(i) < {1'b0, fill_ff}) begin
            word_nx[BYTE_W*i +: BYTE_W] = pack_ext[BYTE_W*i +: BYTE_W];
         end else if (COUNT_W'(i) < fill_sum) begin
            word_nx[BYTE_W*i +: BYTE_W] = run_val_ff;
         end else begin
            word_nx[BYTE_W*i +: BYTE_W] = '0;
         end
      end
   end

   // Status to the controller.
   assign sts.load_run = is_novis || byte_nz;
   assign sts.emit     = emit;
   assign sts.run_done = (run_left_ff == ROW_W'(k));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // Control state of the row.
   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff   <= 1'b0;
         bytes_done_ff <= '0;
         fill_ff       <= '0;
      end else if (cfg_wr) begin
         awaiting_ff   <= 1'b0;
         bytes_done_ff <= '0;
         fill_ff       <= '0;
      end else if (cmd.load) begin
         if (is_novis) begin
            awaiting_ff   <= 1'b0;
            bytes_done_ff <= '0;
            fill_ff       <= '0;
         end else if (awaiting_ff) begin
            awaiting_ff <= 1'b0;
         end else if (!byte_nz) begin
            awaiting_ff <= 1'b1;
         end
      end else if (cmd.step) begin
         if (emit) begin
            fill_ff       <= '0;
            bytes_done_ff <= bd_next;
         end else begin
            fill_ff       <= fill_sum[FILL_W-1:0];
            bytes_done_ff <= bd_sum;
         end
      end
   end

   // Run setup and packing; bytes above the fill are masked on use.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (is_novis) begin
            run_left_ff <= row_len;
            run_val_ff  <= NOVIS_BYTE;
            ovr_ff      <= 1'b0;
         end else if (awaiting_ff) begin
            run_left_ff <= clip ? remaining : ROW_W'(req_in_byte);
            run_val_ff  <= '0;
            ovr_ff      <= clip;
         end else begin
            run_left_ff <= ROW_W'(1);
            run_val_ff  <= req_in_byte;
            ovr_ff      <= 1'b0;
         end
      end else if (cmd.step) begin
         run_left_ff <= rl_next;
         pack_ff     <= word_nx[PACK_W-1:0];
      end
   end

   // Output register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.step && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (cmd.step && emit) begin
         word_ff    <= word_nx;
         count_ff   <= fill_sum;
         row_end_ff <= at_end;
         overrun_ff <= ovr_ff;
         last_ff    <= last_word;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_word     = word_ff;
   assign rsp_valid_bytes  = count_ff;
   assign rsp_row_end      = row_end_ff;
   assign rsp_overrun      = overrun_ff;
   assign rsp_last_of_item = last_ff;

endmodule

// ===== hdl/zrvd_checker.sv =====
module zrvd_props (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [zrvd_pkg::WORD_W-1:0]       rsp_out_word,
   input logic [zrvd_pkg::COUNT_W-1:0]      rsp_valid_bytes,
   input logic                              rsp_row_end,
   input logic                              rsp_last_of_item
);
   import zrvd_pkg::*;

   // A stalled result item keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_word))
      else $error("result word changed while stalled");

   // A word carries one to eight bytes.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_valid_bytes != '0) &&
                    (rsp_valid_bytes <= COUNT_W'(WORD_BYTES)))
      else $error("valid byte count out of range");

   // Only the word that closes a row may be partly filled.
   a_partial_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_row_end |-> (rsp_valid_bytes == COUNT_W'(WORD_BYTES)))
      else $error("partial word before the row end");

   // Runs are clipped at the row end, so a row-closing word ends its item.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_end |-> rsp_last_of_item)
      else $error("row end without last-of-item mark");

endmodule

bind zero_run_visibility_row_decoder zrvd_props u_zrvd_props (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_word    (rsp_out_word),
   .rsp_valid_bytes (rsp_valid_bytes),
   .rsp_row_end     (rsp_row_end),
   .rsp_last_of_item(rsp_last_of_item)
);

// ===== tb/sv/zrvd_checker.sv =====
// Watches the request, result and register ports of the row decoder, predicts
// the packed words that each accepted item should produce, and compares them
// in order against the words that leave the block.
module zrvd_checker #(
   parameter int MAX_ROW_BYTES = zrvd_pkg::DEF_MAX_ROW_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              req_type,
   input  logic [zrvd_pkg::BYTE_W-1:0]       req_in_byte,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [zrvd_pkg::WORD_W-1:0]       rsp_out_word,
   input  logic [zrvd_pkg::COUNT_W-1:0]      rsp_valid_bytes,
   input  logic                              rsp_row_end,
   input  logic                              rsp_overrun,
   input  logic                              rsp_last_of_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [zrvd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [zrvd_pkg::CSR_DATA_W-1:0]   pwdata,
   input  logic                              pready,
   output int                                mismatches,
   output int                                words_pending
);

   import zrvd_pkg::*;

   typedef struct {
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] nbytes;
      logic               row_end;
      logic               overrun;
      logic               last;
   } row_word_type;

   // Words still owed by the block, oldest first, and the words of the item
   // being decoded right now.
   row_word_type expected_words[$];
   row_word_type item_words[$];

   // Shadow of the decoder state and its one register.
   logic [CLUSTER_COUNT_W-1:0] clusters;
   logic                       count_next;
   int                         row_pos;
   logic [WORD_W-1:0]          pack_bytes;
   int                         pack_count;
   int                         fails = 0;

   // Bytes per row, held between one and the largest row.
   function automatic int row_bytes();
      int r;
      r = (int'(clusters) + 7) >> 3;
      if (r < 1) begin
         r = 1;
      end
      if (r > MAX_ROW_BYTES) begin
         r = MAX_ROW_BYTES;
      end
      return r;
   endfunction

   task automatic clear_row();
      count_next = 1'b0;
      row_pos    = 0;
      pack_bytes = '0;
      pack_count = 0;
   endtask

   // Add one decoded byte; a word goes out when full or when the row completes.
   task automatic place_byte(input logic [BYTE_W-1:0] b);
      row_word_type w;
      logic         done;
      pack_bytes[8*pack_count +: 8] = b;
      pack_count++;
      row_pos++;
      done = (row_pos >= row_bytes());
      if (pack_count >= WORD_BYTES || done) begin
         w.word    = pack_bytes;
         w.nbytes  = COUNT_W'(pack_count);
         w.row_end = done;
         w.overrun = 1'b0;
         w.last    = 1'b0;
         item_words.push_back(w);
         pack_bytes = '0;
         pack_count = 0;
         if (done) begin
            row_pos = 0;
         end
      end
   endtask

   // Expand one accepted item into the words it should cause.
   task automatic decode_item(input logic kind, input logic [BYTE_W-1:0] b);
      int   rlen;
      int   run;
      int   room;
      logic clipped;
      rlen    = row_bytes();
      clipped = 1'b0;
      item_words.delete();
      if (kind == REQ_NOVIS) begin
         clear_row();
         for (int i = 0; i < rlen; i++) begin
            place_byte(NOVIS_BYTE);
         end
      end else if (count_next) begin
         count_next = 1'b0;
         room = (row_pos < rlen) ? rlen - row_pos : 0;
         run  = int'(b);
         if (run > room) begin
            run     = room;
            clipped = 1'b1;
         end
         repeat (run) place_byte('0);
      end else if (b != '0) begin
         place_byte(b);
      end else begin
         count_next = 1'b1;
      end
      foreach (item_words[k]) begin
         item_words[k].overrun = clipped;
         item_words[k].last    = (k == item_words.size() - 1);
         expected_words.push_back(item_words[k]);
      end
   endtask

   function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                       logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         fails++;
      end
   endfunction

   // Compare one word leaving the block with the oldest prediction.
   task automatic check_word();
      row_word_type w;
      if (expected_words.size() == 0) begin
         $display("%0t: unexpected word: expected none, actual %h (%0d bytes)",
                  $time, rsp_out_word, rsp_valid_bytes);
         fails++;
      end else begin
         w = expected_words.pop_front();
         check_field("out_word", w.word, rsp_out_word);
         check_field("valid_bytes", WORD_W'(w.nbytes), WORD_W'(rsp_valid_bytes));
         check_field("row_end", WORD_W'(w.row_end), WORD_W'(rsp_row_end));
         check_field("overrun", WORD_W'(w.overrun), WORD_W'(rsp_overrun));
         check_field("last_of_item", WORD_W'(w.last), WORD_W'(rsp_last_of_item));
      end
   endtask

   // Everything is sampled at the rising edge, before that edge takes effect.
   always @(posedge clock) begin
      if (reset) begin
         clusters = CLUSTER_COUNT_RESET;
         clear_row();
         expected_words.delete();
      end else begin
         // A write to the cluster count drops any partial row.
         if (psel && penable && pwrite && pready) begin
            if (int'(paddr >> 2) == int'(REG_CLUSTER_COUNT)) begin
               clusters = pwdata[CLUSTER_COUNT_W-1:0];
               clear_row();
            end
         end
         if (req_valid && req_ready) begin
            decode_item(req_type, req_in_byte);
         end
         if (rsp_valid && rsp_ready) begin
            check_word();
         end
      end
      mismatches    <= fails;
      words_pending <= expected_words.size();
   end

endmodule

// ===== tb/sv/tb_zero_run_visibility_row_decoder.sv =====
// Drives compressed bytes, no-vis requests and cluster count writes into the
// row decoder, stalls both channels at random, and reports the verdict that
// the checker's counts give.
module tb_zero_run_visibility_row_decoder;

   import zrvd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [CSR_ADDR_W-1:0] CLUSTER_COUNT_ADDR = CSR_ADDR_W'(4 * REG_CLUSTER_COUNT);
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR =
      CSR_ADDR_W'(4 * (int'(REG_CLUSTER_COUNT) + 1));

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = REQ_STREAM;
   logic [BYTE_W-1:0]     req_in_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WORD_W-1:0]     rsp_out_word;
   logic [COUNT_W-1:0]    rsp_valid_bytes;
   logic                  rsp_row_end;
   logic                  rsp_overrun;
   logic                  rsp_last_of_item;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatches;
   int                    words_pending;
   int                    cycles = 0;
   logic                  calm = 1'b0;
   int                    cur_clusters = int'(CLUSTER_COUNT_RESET);

   zero_run_visibility_row_decoder u_dut (.*);

   zrvd_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // A pause comes with a chance of about one in five, except during a calm stretch.
   function automatic bit take_break();
      return !calm && ($urandom_range(99) < 20);
   endfunction

   // The result side stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !take_break();
      end
   end

   // Offer one item and hold it until accepted; valid stays high afterward
   // so that back-to-back items never drop it within one step.
   task automatic offer_byte(input logic kind, input logic [BYTE_W-1:0] b);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering, wait for every predicted word, then let the block settle.
   // A clock edge passes first so that the pending count covers the last item.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input int cc);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      // Bits above the register are random and must be ignored.
      pwdata  <= ($urandom & 32'hFFFF_F000) | CSR_DATA_W'(cc & 32'hFFF);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mostly literals and well-formed runs, with some no-vis rows, cancelled
   // markers and raw noise.
   task automatic random_items(input int n);
      int sent;
      int pick;
      int span;
      span = ((cur_clusters + 7) >> 3) + 3;
      if (span > 255) begin
         span = 255;
      end
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            offer_byte(REQ_STREAM, BYTE_W'($urandom_range(255, 1)));
            sent += 1;
         end else if (pick < 80) begin
            offer_byte(REQ_STREAM, '0);
            offer_byte(REQ_STREAM, BYTE_W'($urandom_range(span, 0)));
            sent += 2;
         end else if (pick < 88) begin
            offer_byte(REQ_NOVIS, BYTE_W'($urandom));
            sent += 1;
         end else if (pick < 94) begin
            offer_byte(REQ_STREAM, '0);
            offer_byte(REQ_NOVIS, BYTE_W'($urandom));
            sent += 2;
         end else begin
            offer_byte(REQ_STREAM, BYTE_W'($urandom));
            sent += 1;
         end
      end
   endtask

   // New cluster count, written while the block is idle, then random items.
   task automatic run_phase(input int cc, input int n, input logic quiet);
      drain();
      cur_clusters = cc;
      csr_write(CLUSTER_COUNT_ADDR, cc);
      calm = quiet;
      random_items(n);
      calm = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset row of 256 bytes: literals at the byte extremes, a zero-length
      // run, a run clipped at the row end, then a no-vis row.
      offer_byte(REQ_STREAM, 8'h01);
      offer_byte(REQ_STREAM, 8'hFF);
      offer_byte(REQ_STREAM, 8'h80);
      offer_byte(REQ_STREAM, 8'h00);
      offer_byte(REQ_STREAM, 8'h00);
      offer_byte(REQ_STREAM, 8'h00);
      offer_byte(REQ_STREAM, 8'hFF);
      offer_byte(REQ_NOVIS, 8'h00);

      // A write to an unmapped register changes nothing; then a zero count.
      drain();
      csr_write(UNMAPPED_ADDR, 12'hFFF);
      csr_write(CLUSTER_COUNT_ADDR, 0);
      cur_clusters = 0;

      // One-byte rows: every byte ends a row, runs clip, no-vis cancels a marker.
      offer_byte(REQ_STREAM, 8'h7F);
      offer_byte(REQ_STREAM, 8'h00);
      offer_byte(REQ_STREAM, 8'h05);
      offer_byte(REQ_STREAM, 8'h00);
      offer_byte(REQ_NOVIS, 8'hA5);
      offer_byte(REQ_STREAM, 8'h55);
      offer_byte(REQ_NOVIS, 8'hFF);

      // Partial row cut short by a register write, then the saturated row.
      drain();
      csr_write(CLUSTER_COUNT_ADDR, 20);
      offer_byte(REQ_STREAM, 8'hAA);
      drain();
      csr_write(CLUSTER_COUNT_ADDR, 4095);
      cur_clusters = 4095;
      offer_byte(REQ_NOVIS, 8'h3C);
      offer_byte(REQ_STREAM, 8'h42);

      // Random part over several row lengths, the extremes among them.
      run_phase(0, 20, 1'b0);
      run_phase(1, 30, 1'b0);
      run_phase(57, 60, 1'b0);
      run_phase(130, 60, 1'b1);
      run_phase(4095, 20, 1'b0);
      run_phase($urandom_range(400, 1), 60, 1'b0);
      run_phase(2048, 20, 1'b0);
      run_phase(300, 60, 1'b0);

      drain();
      if (mismatches == 0 && words_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
